FILE: rtl/core/zve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zve_pkg
// Shared types, widths and the zigzag fold for the varint encoder.
// ----------------------------------------------------------------------------
package zve_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned GroupW = 7;
  localparam int unsigned ByteW  = 8;

  // one output word: encoded byte plus end-of-value flag
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
  } zve_word_t;

  // non-negative v -> 2v, negative v -> 2*(~v)+1
  function automatic logic [ValueW-1:0] zigzag_fold(input logic [ValueW-1:0] raw);
    logic [ValueW-1:0] sign_mask;
    sign_mask = {ValueW{raw[ValueW-1]}};
    return {raw[ValueW-2:0], 1'b0} ^ sign_mask;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/zve_slicer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zve_slicer
// Holds the folded code of one value and peels off one 7-bit group per
// cycle while the output register can take a word.
// ----------------------------------------------------------------------------
module zve_slicer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic signed [zve_pkg::ValueW-1:0] value_i,
  input  wire logic                         out_ready_i,
  output      logic                         word_valid_o,
  output      zve_pkg::zve_word_t           word_o
);
  import zve_pkg::*;

  logic [ValueW-1:0] code_q, code_d;
  logic              busy_q, busy_d;
  logic [ValueW-1:0] rest;
  logic              more;
  logic              emit;
  logic              load;

  assign rest = code_q >> GroupW;
  assign more = (rest != '0);
  assign emit = busy_q && out_ready_i;

  // free when idle or when the final group leaves this cycle
  assign in_stall_o = busy_q && !(emit && !more);
  assign load       = in_valid_i && !in_stall_o;

  assign word_valid_o    = busy_q;
  assign word_o.out_byte = {more, code_q[GroupW-1:0]};
  assign word_o.last     = !more;

  always_comb begin
    code_d = code_q;
    busy_d = busy_q;
    if (emit) begin
      code_d = rest;
      busy_d = more;
    end
    if (load) begin
      code_d = zigzag_fold(value_i);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

endmodule
`default_nettype wire

FILE: rtl/core/zve_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zve_out_reg
// Output register; takes a new word whenever empty or being drained.
// ----------------------------------------------------------------------------
module zve_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               word_valid_i,
  input  wire zve_pkg::zve_word_t word_i,
  output      logic               ready_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [zve_pkg::ByteW-1:0] out_byte_o,
  output      logic               last_o
);
  import zve_pkg::*;

  logic      valid_q, valid_d;
  zve_word_t word_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? word_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && word_valid_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = word_q.out_byte;
  assign last_o      = word_q.last;

endmodule
`default_nettype wire

FILE: rtl/core/zigzag_varint_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zigzag_varint_encoder
// Zigzag varint encoder for signed 32-bit values.
//
// Input channel: value_i with in_valid_i / in_stall_o; a word is taken at a
// clock edge with valid high and stall low. Output channel: out_byte_o and
// last_o with out_valid_o / out_stall_i. Each value gives one to five bytes,
// least significant 7-bit group first, bit 7 set while more bytes follow,
// last_o high on the final byte.
// The first byte passes through the slicer's code register and then the
// output register before it shows at out_valid_o. Throughput: one byte per
// cycle while the output register can drain; the next value is taken in the
// cycle its predecessor's final byte moves into the output register.
// The slicer's code register sets that rate: one group leaves per cycle.
// Reset clears the valid flags of the slicer and output register; nothing
// else needs clearing. While out_stall_i is high a full output register
// holds its word, the slicer waits; in_stall_o rises once the slicer is full.
// ----------------------------------------------------------------------------
module zigzag_varint_encoder (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic signed [zve_pkg::ValueW-1:0] value_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [zve_pkg::ByteW-1:0]         out_byte_o,
  output      logic                              last_o
);
  import zve_pkg::*;

  logic      word_valid;
  zve_word_t word;
  logic      out_ready;

  zve_slicer u_slicer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_ready_i  (out_ready),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  zve_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (word),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

FILE: verif/zigzag_varint_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_varint_encoder_test
// Self-checking bench for the zigzag varint encoder. Each accepted value is
// folded and sliced into 7-bit groups by a local predictor, and every output
// word is compared field by field with the oldest predicted word. Directed
// corner values come first, then random values of every byte length, under
// random gaps on both sides, a long receiver hold and a drain pause.
// ----------------------------------------------------------------------------
module zigzag_varint_encoder_test;
  import zve_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned MaxBytes   = 5;
  localparam int unsigned MaxGap     = 17;
  localparam int unsigned ReportMax  = 10;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic signed [ValueW-1:0] value_i     = '0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [ByteW-1:0]         out_byte_o;
  logic                     last_o;

  zve_word_t   expected_words[$];
  int unsigned send_gap_max  = MaxGap;
  int unsigned recv_stall_max = MaxGap;
  int unsigned recv_hold_req = 0;
  int unsigned values_sent   = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned long_holds    = 0;
  int unsigned fill_stalls   = 0;
  int unsigned length_seen[1:MaxBytes];

  zigzag_varint_encoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // fold to an unsigned code, then cut it into groups, low group first
  function automatic void predict_encoding(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] code;
    zve_word_t         w;
    int unsigned       n;
    code = v[ValueW-1] ? {~v[ValueW-2:0], 1'b1} : {v[ValueW-2:0], 1'b0};
    for (n = 0; n < MaxBytes; n++) begin
      w.out_byte = {1'b0, code[GroupW-1:0]};
      code = code >> GroupW;
      if (code != '0 && n < MaxBytes - 1) begin
        w.out_byte[ByteW-1] = 1'b1;
        w.last = 1'b0;
        expected_words.push_back(w);
      end else begin
        w.last = 1'b1;
        expected_words.push_back(w);
        length_seen[n+1]++;
        break;
      end
    end
  endfunction

  // random value with a random magnitude class so every length shows up
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] v;
    int unsigned       nbits;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
    end else begin
      nbits = $urandom_range(1, ValueW - 1);
      v = $urandom & ((32'h1 << nbits) - 1);
      if ($urandom_range(0, 1) == 1) v = ~v;
    end
    return v;
  endfunction

  // offer one word after a random gap; returns at the accepting edge
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) begin
      fill_stalls++;
      @(posedge clk_i);
    end
    predict_encoding(v);
    values_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corner_values();
    logic [ValueW-1:0] corners[$];
    send_gap_max   = 3;
    recv_stall_max = 3;
    corners = '{32'sd0, 32'sd1, -32'sd1, 32'sd63, -32'sd64, 32'sd64, -32'sd65,
                32'sd4095, -32'sd4096, 32'sd4096, 32'sd524287, -32'sd524288,
                32'sd524288, 32'sd67108863, -32'sd67108864, 32'sd67108864,
                32'sh7fff_ffff, 32'sh8000_0000, 32'sh5555_5555, 32'shaaaa_aaaa,
                32'sh4000_0000, -32'sd2};
    foreach (corners[i]) send_value(corners[i]);
  endtask

  // random values, switching pacing every 25 values
  task automatic test_random_values(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 3))
          0: begin send_gap_max = 0;      recv_stall_max = 0;      end
          1: begin send_gap_max = MaxGap; recv_stall_max = 0;      end
          2: begin send_gap_max = 0;      recv_stall_max = MaxGap; end
          default: begin send_gap_max = MaxGap; recv_stall_max = MaxGap; end
        endcase
      end
      send_value(pick_value());
    end
  endtask

  // receiver holds off while the sender keeps offering five-byte values
  task automatic test_long_hold();
    send_gap_max   = 0;
    recv_stall_max = 0;
    recv_hold_req  = 90;
    for (int unsigned i = 0; i < 12; i++) begin
      send_value(($urandom & 32'h7fff_ffff) | 32'h4000_0000);
    end
  endtask

  // sender goes quiet until every predicted word is out, then resumes
  task automatic test_drain_pause();
    send_gap_max   = 2;
    recv_stall_max = MaxGap;
    for (int unsigned i = 0; i < 6; i++) send_value(pick_value());
    wait_drained();
    for (int unsigned i = 0; i < 6; i++) send_value(pick_value());
  endtask

  initial begin : receiver
    int unsigned hold;
    forever begin
      if (recv_hold_req != 0) begin
        hold = recv_hold_req;
        recv_hold_req = 0;
        long_holds++;
      end else begin
        hold = $urandom_range(0, recv_stall_max);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : word_check
    zve_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: unexpected word byte=%02h last=%0b", $realtime, out_byte_o, last_o);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_byte_o !== want.out_byte || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("%0t: word %0d expected byte=%02h last=%0b, got byte=%02h last=%0b",
                     $realtime, words_checked, want.out_byte, want.last, out_byte_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned idle_cycles;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    foreach (length_seen[i]) length_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_values();
    test_random_values(200);
    test_long_hold();
    test_drain_pause();

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("encoded %0d values into %0d words; lengths 1..5: %0d %0d %0d %0d %0d",
             values_sent, words_checked, length_seen[1], length_seen[2], length_seen[3],
             length_seen[4], length_seen[5]);
    $display("input stalled %0d cycles, %0d long receiver hold(s), %0d mismatch(es)",
             fill_stalls, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
